// File: hw/rtl/sdcd_pkg.sv
// sdcd_pkg: shared constants, field widths and the month length table
// for the serial day to calendar date block; no dependencies
package sdcd_pkg;

	// supported years run from BASE_YEAR to BASE_YEAR + YEAR_SPAN - 1
	localparam int unsigned YEAR_SPAN     = 256;
	localparam int unsigned BASE_YEAR     = 1900;
	localparam int unsigned DAYS_LEAP     = 366;
	localparam int unsigned DAYS_COMMON   = 365;
	localparam int unsigned FEB_LEAP_DAYS = 29;
	localparam int unsigned WEEK_LEN      = 7;

	// field widths
	localparam int unsigned SERIAL_W = 17;
	localparam int unsigned YEAR_W   = 12;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned WDAY_W   = 3;

	// year counter and shared unit operand
	localparam int unsigned SPAN_CNT_W = $clog2(YEAR_SPAN + 1);
	localparam int unsigned OPND_W     = 9;

	// leap rule residues of the base year
	localparam int unsigned BASE_MOD4   = BASE_YEAR % 4;
	localparam int unsigned BASE_MOD100 = BASE_YEAR % 100;
	localparam int unsigned BASE_MOD400 = BASE_YEAR % 400;

	localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_LAST = MONTH_W'(11);
	localparam int unsigned        N_MONTHS   = 12;

	localparam logic [DAY_W-1:0] MONTH_LEN [N_MONTHS] = '{
		DAY_W'(31), DAY_W'(28), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30),
		DAY_W'(31), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30), DAY_W'(31)
	};

	// days in month m (0 is January), february stretched in a leap year
	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] d;
		if (m <= MONTH_LAST) begin
			d = MONTH_LEN[m];
		end else begin
			d = '0;
		end
		if (leap && m == MONTH_FEB) begin
			d = DAY_W'(FEB_LEAP_DAYS);
		end
		return d;
	endfunction

endpackage

// File: hw/rtl/sdcd_if.sv
// sdcd_if: valid/ready channel interfaces for the serial day input and
// the calendar date result; depends on sdcd_pkg
interface sdcd_in_if;
	import sdcd_pkg::*;

	logic                valid;
	logic                ready;
	logic [SERIAL_W-1:0] day_serial;

	modport source (output valid, output day_serial, input ready);
	modport sink (input valid, input day_serial, output ready);
endinterface

interface sdcd_out_if;
	import sdcd_pkg::*;

	logic               valid;
	logic               ready;
	logic [YEAR_W-1:0]  year;
	logic [MONTH_W-1:0] month;
	logic [DAY_W-1:0]   day_of_month;
	logic [WDAY_W-1:0]  weekday;
	logic               invalid;

	modport source (output valid, output year, output month, output day_of_month,
		output weekday, output invalid, input ready);
	modport sink (input valid, input year, input month, input day_of_month,
		input weekday, input invalid, output ready);
endinterface

// File: hw/rtl/serial_day_to_calendar_date_top.sv
// serial_day_to_calendar_date_top: turns a day serial (1 is 1 January 1900)
// into Gregorian year, month, day of month and weekday
// depends on sdcd_pkg and the channel interfaces in sdcd_if
//
// channel | dir | beat payload                                   | handshake
// --------+-----+------------------------------------------------+------------
// req     | in  | day_serial                                     | valid/ready
// rsp     | out | year, month, day_of_month, weekday, invalid    | valid/ready
//
// one beat is taken in the idle state; the sequencer then removes one whole
// year per cycle and then one month per cycle, all through one shared
// compare/subtract unit, and last hands the date to the output register once
// that register is free
// req.ready is high only while idle; a result waiting in the output register
// does not block the next beat, only the hand-over of the following result
// arst_n clears the sequencer and the output valid; no clearing pass needed
module serial_day_to_calendar_date_top (
	input  logic       clk,
	input  logic       arst_n,
	sdcd_in_if.sink    req,
	sdcd_out_if.source rsp
);
	import sdcd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_YEAR,
		ST_MONTH,
		ST_DONE
	} state_t;

	localparam logic [SPAN_CNT_W-1:0] SPAN_LAST = SPAN_CNT_W'(YEAR_SPAN - 1);

	state_t                state_q;
	logic [SERIAL_W-1:0]   rem_q;       // days still to place
	logic [YEAR_W-1:0]     yr_q;        // current year
	logic [SPAN_CNT_W-1:0] span_q;      // years removed so far
	logic [1:0]            c4_q;        // year mod 4
	logic [6:0]            c100_q;      // year mod 100
	logic [8:0]            c400_q;      // year mod 400
	logic                  leap_q;      // leap flag of the found year
	logic [MONTH_W-1:0]    mon_q;       // month index, 0 is January
	logic                  found_q;
	logic [WDAY_W-1:0]     wday_q;

	// output register
	logic                  rvalid_q;
	logic [YEAR_W-1:0]     ryear_q;
	logic [MONTH_W-1:0]    rmonth_q;
	logic [DAY_W-1:0]      rday_q;
	logic [WDAY_W-1:0]     rwday_q;
	logic                  rinv_q;

	logic                  leap_now;
	logic [OPND_W-1:0]     opnd;
	logic                  unit_le;
	logic [SERIAL_W-1:0]   unit_diff;
	logic                  hand_over;

	logic [5:0]            wsum1;
	logic [3:0]            wsum2;
	logic [3:0]            wsum3;
	logic [WDAY_W-1:0]     wday_in;

	// gregorian leap rule from the running residues
	assign leap_now = (c4_q == 2'd0) && ((c100_q != 7'd0) || (c400_q == 9'd0));

	// hand over once the output register is free
	assign hand_over = (state_q == ST_DONE) && (!rvalid_q || rsp.ready);

	// shared unit: compare and subtract a year or a month length
	always_comb begin
		if (state_q == ST_MONTH) begin
			opnd = OPND_W'(month_days(mon_q, leap_q));
		end else begin
			opnd = leap_now ? OPND_W'(DAYS_LEAP) : OPND_W'(DAYS_COMMON);
		end
		unit_le   = rem_q <= SERIAL_W'(opnd);
		unit_diff = rem_q - SERIAL_W'(opnd);
	end

	// serial mod 7: 8 is 1 mod 7, so fold octal digits, then one correction
	always_comb begin
		wsum1 = 6'(req.day_serial[2:0])   + 6'(req.day_serial[5:3])
		      + 6'(req.day_serial[8:6])   + 6'(req.day_serial[11:9])
		      + 6'(req.day_serial[14:12]) + 6'(req.day_serial[16:15]);
		wsum2 = 4'(wsum1[2:0]) + 4'(wsum1[5:3]);
		wsum3 = 4'(wsum2[2:0]) + 4'(wsum2[3]);
		if (wsum3 >= 4'(WEEK_LEN)) begin
			wday_in = WDAY_W'(wsum3 - 4'(WEEK_LEN));
		end else begin
			wday_in = WDAY_W'(wsum3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rvalid_q <= 1'b0;
		end else begin
			if (hand_over) begin
				rvalid_q <= 1'b1;
			end else if (rsp.ready) begin
				rvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						rem_q   <= req.day_serial;
						yr_q    <= YEAR_W'(BASE_YEAR);
						span_q  <= '0;
						c4_q    <= 2'(BASE_MOD4);
						c100_q  <= 7'(BASE_MOD100);
						c400_q  <= 9'(BASE_MOD400);
						found_q <= 1'b0;
						wday_q  <= wday_in;
						// serial zero has no date
						state_q <= (req.day_serial == '0) ? ST_DONE : ST_YEAR;
					end
				end
				ST_YEAR: begin
					if (unit_le) begin
						found_q <= 1'b1;
						leap_q  <= leap_now;
						mon_q   <= '0;
						state_q <= ST_MONTH;
					end else begin
						rem_q   <= unit_diff;
						yr_q    <= yr_q + 1'b1;
						span_q  <= span_q + 1'b1;
						c4_q    <= c4_q + 1'b1;
						c100_q  <= (c100_q == 7'd99) ? 7'd0 : c100_q + 1'b1;
						c400_q  <= (c400_q == 9'd399) ? 9'd0 : c400_q + 1'b1;
						// past the last supported year
						if (span_q == SPAN_LAST) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_MONTH: begin
					if (unit_le || mon_q == MONTH_LAST) begin
						state_q <= ST_DONE;
					end else begin
						rem_q <= unit_diff;
						mon_q <= mon_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (hand_over) begin
						rwday_q  <= wday_q;
						rinv_q   <= !found_q;
						if (found_q) begin
							ryear_q  <= yr_q;
							rmonth_q <= mon_q + 1'b1;
							rday_q   <= rem_q[DAY_W-1:0];
						end else begin
							ryear_q  <= '0;
							rmonth_q <= '0;
							rday_q   <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req.ready        = (state_q == ST_IDLE);
	assign rsp.valid        = rvalid_q;
	assign rsp.year         = ryear_q;
	assign rsp.month        = rmonth_q;
	assign rsp.day_of_month = rday_q;
	assign rsp.weekday      = rwday_q;
	assign rsp.invalid      = rinv_q;

endmodule

// File: hw/rtl/sdcd_chk.sv
// sdcd_chk: port-level checks on the serial day to calendar date block,
// bound to serial_day_to_calendar_date_top; depends on sdcd_pkg
module sdcd_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [sdcd_pkg::YEAR_W-1:0]  year,
	input logic [sdcd_pkg::MONTH_W-1:0] month,
	input logic [sdcd_pkg::DAY_W-1:0]   day_of_month,
	input logic [sdcd_pkg::WDAY_W-1:0]  weekday,
	input logic                         invalid
);
	import sdcd_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(year) && $stable(month)
			&& $stable(day_of_month) && $stable(weekday) && $stable(invalid))
		else $error("result beat changed while stalled");

	// one beat at a time: input closes after an accepted beat
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input still open after accepted beat");

	// an invalid date carries zero fields
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid |-> year == '0 && month == '0 && day_of_month == '0)
		else $error("invalid result with non-zero date fields");

	// a valid date is in range
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !invalid |-> month >= MONTH_W'(1) && month <= MONTH_W'(N_MONTHS)
			&& day_of_month >= DAY_W'(1) && day_of_month <= DAY_W'(31)
			&& weekday < WDAY_W'(WEEK_LEN))
		else $error("date fields out of range");

endmodule

bind serial_day_to_calendar_date_top sdcd_chk u_sdcd_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (req.valid),
	.in_ready     (req.ready),
	.out_valid    (rsp.valid),
	.out_ready    (rsp.ready),
	.year         (rsp.year),
	.month        (rsp.month),
	.day_of_month (rsp.day_of_month),
	.weekday      (rsp.weekday),
	.invalid      (rsp.invalid)
);

// File: tb/tb_serial_day_to_calendar_date_top.sv
// tb_serial_day_to_calendar_date_top: self-checking bench for the serial day to calendar
// date block; predicts each date from the serial and checks every result beat
// depends on sdcd_pkg, the channel interfaces in sdcd_if and serial_day_to_calendar_date_top
module tb_serial_day_to_calendar_date_top;
	import sdcd_pkg::*;

	// one expected result, tagged with the serial that caused it
	typedef struct packed {
		logic [SERIAL_W-1:0] serial;
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    dom;
		logic [WDAY_W-1:0]   weekday;
		logic                invalid;
	} date_beat_t;

	localparam int unsigned MAX_WAIT    = 14;
	localparam int unsigned DRAIN_TAIL  = 300;   // a little over one full conversion
	localparam int unsigned REPORT_CAP  = 40;
	localparam int unsigned CHUNK_LEN   = 100;
	localparam int unsigned RAND_CHUNKS = 17;

	logic clk;
	logic arst_n;

	sdcd_in_if  req_ch ();
	sdcd_out_if rsp_ch ();

	serial_day_to_calendar_date_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// dates still owed by the block, oldest first
	date_beat_t pending_dates[$];
	date_beat_t rsp_want;

	int unsigned last_serial;      // 31 december of the last supported year
	bit          idle_on;          // random gaps on both sides when set
	int unsigned mismatch_count;
	int unsigned sent_count;
	int unsigned dated_count;
	int unsigned undated_count;
	int unsigned checked_count;

	// 12 time unit period
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// generous bound on the whole run
	initial begin
		#30_000_000;
		$display("timeout: %0d results still pending", pending_dates.size());
		$display("Verification failed");
		$finish;
	end

	// ---------------------------------------------------------------------
	// calendar arithmetic of the bench
	// ---------------------------------------------------------------------

	function automatic bit leap_year(input int unsigned yr);
		return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
	endfunction

	// month is 1 based here
	function automatic int unsigned month_length(input int unsigned mo, input bit leap);
		case (mo)
			2: begin
				return leap ? FEB_LEAP_DAYS : 28;
			end
			4, 6, 9, 11: begin
				return 30;
			end
			default: begin
				return 31;
			end
		endcase
	endfunction

	// serial of a given date, counting 1 january of the base year as 1
	function automatic int unsigned serial_of_date(input int unsigned yr, input int unsigned mo,
			input int unsigned dom);
		int unsigned total;
		total = dom;
		for (int unsigned y = BASE_YEAR; y < yr; y++) begin
			total += leap_year(y) ? DAYS_LEAP : DAYS_COMMON;
		end
		for (int unsigned m = 1; m < mo; m++) begin
			total += month_length(m, leap_year(yr));
		end
		return total;
	endfunction

	// strip whole years, then whole months; anything left over is the day of month
	function automatic date_beat_t serial_to_date(input logic [SERIAL_W-1:0] serial);
		date_beat_t  d;
		int unsigned left;
		int unsigned yr;
		int unsigned mo;
		int unsigned year_len;
		bit          hit;
		bit          leap;
		d         = '0;
		d.serial  = serial;
		d.weekday = WDAY_W'(serial % WEEK_LEN);
		d.invalid = 1'b1;
		left      = serial;
		yr        = BASE_YEAR;
		hit       = 1'b0;
		leap      = 1'b0;
		if (serial != 0) begin
			for (int unsigned i = 0; i < YEAR_SPAN; i++) begin
				yr       = BASE_YEAR + i;
				leap     = leap_year(yr);
				year_len = leap ? DAYS_LEAP : DAYS_COMMON;
				if (left <= year_len) begin
					hit = 1'b1;
					break;
				end
				left -= year_len;
			end
		end
		if (hit) begin
			mo = 1;
			while (mo < 12 && left > month_length(mo, leap)) begin
				left -= month_length(mo, leap);
				mo++;
			end
			d.year    = YEAR_W'(yr);
			d.month   = MONTH_W'(mo);
			d.dom     = DAY_W'(left);
			d.invalid = 1'b0;
		end
		return d;
	endfunction

	// ---------------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------------

	function automatic int unsigned draw_wait();
		return idle_on ? $urandom_range(0, MAX_WAIT) : 0;
	endfunction

	// mostly plain dates, a fair share of year and month edges, some out of range
	function automatic logic [SERIAL_W-1:0] pick_serial();
		int unsigned kind;
		int unsigned yr;
		int unsigned mo;
		kind = $urandom_range(0, 19);
		yr   = BASE_YEAR + $urandom_range(0, YEAR_SPAN - 1);
		mo   = $urandom_range(1, 12);
		if (kind < 12) begin
			return SERIAL_W'($urandom_range(1, last_serial));
		end else if (kind < 14) begin
			// new year's day or the eve before it (serial zero for the base year)
			return SERIAL_W'(serial_of_date(yr, 1, 1) - $urandom_range(0, 1));
		end else if (kind < 16) begin
			// first of a month or the last day of the month before
			return SERIAL_W'(serial_of_date(yr, mo, 1) - $urandom_range(0, 1));
		end else if (kind < 18) begin
			return SERIAL_W'($urandom_range(last_serial + 1, (1 << SERIAL_W) - 1));
		end else begin
			return SERIAL_W'($urandom());
		end
	endfunction

	// entered and left at a falling edge; valid stays high on return so a
	// following beat with no gap keeps it up without a drop
	task automatic send_serial(input logic [SERIAL_W-1:0] serial);
		int unsigned gap;
		date_beat_t  want;
		gap = draw_wait();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.day_serial <= serial;
		req_ch.valid      <= 1'b1;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		want = serial_to_date(serial);
		pending_dates.push_back(want);
		sent_count++;
		if (want.invalid) begin
			undated_count++;
		end else begin
			dated_count++;
		end
		@(negedge clk);
	endtask

	// hold the sender off until every owed date has come back
	task automatic wait_all_results();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (pending_dates.size() != 0);
	endtask

	task automatic report_mismatch(input string what, input logic [SERIAL_W-1:0] serial,
			input int unsigned got, input int unsigned want);
		mismatch_count++;
		if (mismatch_count <= REPORT_CAP) begin
			$display("mismatch: %s for serial %0d, got %0d, want %0d", what, serial, got, want);
		end
	endtask

	// ---------------------------------------------------------------------
	// result side: random back-pressure and the field-by-field check
	// ---------------------------------------------------------------------

	initial begin
		int unsigned stall;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			stall = draw_wait();
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
		end
	end

	always @(posedge clk) begin
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_dates.size() == 0) begin
				report_mismatch("result beat with nothing owed, year", '0, rsp_ch.year, 0);
			end else begin
				rsp_want = pending_dates.pop_front();
				checked_count++;
				if (rsp_ch.year !== rsp_want.year) begin
					report_mismatch("year", rsp_want.serial, rsp_ch.year, rsp_want.year);
				end
				if (rsp_ch.month !== rsp_want.month) begin
					report_mismatch("month", rsp_want.serial, rsp_ch.month, rsp_want.month);
				end
				if (rsp_ch.day_of_month !== rsp_want.dom) begin
					report_mismatch("day_of_month", rsp_want.serial, rsp_ch.day_of_month,
						rsp_want.dom);
				end
				if (rsp_ch.weekday !== rsp_want.weekday) begin
					report_mismatch("weekday", rsp_want.serial, rsp_ch.weekday,
						rsp_want.weekday);
				end
				if (rsp_ch.invalid !== rsp_want.invalid) begin
					report_mismatch("invalid", rsp_want.serial, rsp_ch.invalid,
						rsp_want.invalid);
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------

	// first and last supported days, month ends, the leap rule in all its forms
	task automatic test_calendar_edges();
		send_serial(SERIAL_W'(1));
		send_serial(SERIAL_W'(6));
		send_serial(SERIAL_W'(7));
		// 1900 is a century year and not a leap year
		send_serial(SERIAL_W'(serial_of_date(1900, 2, 28)));
		send_serial(SERIAL_W'(serial_of_date(1900, 3, 1)));
		send_serial(SERIAL_W'(serial_of_date(1900, 12, 31)));
		send_serial(SERIAL_W'(serial_of_date(1901, 1, 1)));
		send_serial(SERIAL_W'(serial_of_date(1904, 2, 29)));
		send_serial(SERIAL_W'(serial_of_date(1904, 3, 1)));
		// 2000 divides by 400, so it is a leap year
		send_serial(SERIAL_W'(serial_of_date(2000, 2, 29)));
		send_serial(SERIAL_W'(serial_of_date(2000, 12, 31)));
		send_serial(SERIAL_W'(serial_of_date(2100, 2, 28)));
		send_serial(SERIAL_W'(serial_of_date(2100, 3, 1)));
		send_serial(SERIAL_W'(serial_of_date(2024, 7, 31)));
		// alternating bit patterns and the top bit on its own
		send_serial(SERIAL_W'('h0AAAA));
		send_serial(SERIAL_W'('h15555));
		send_serial(SERIAL_W'('h10000));
		send_serial(SERIAL_W'(last_serial));
	endtask

	// serial zero, just past the last year, a serial well past it and the all-ones serial
	task automatic test_out_of_range();
		send_serial(SERIAL_W'(0));
		send_serial(SERIAL_W'(last_serial + 1));
		send_serial(SERIAL_W'(100000));
		send_serial(SERIAL_W'((1 << SERIAL_W) - 1));
	endtask

	// no gaps on either side
	task automatic test_full_rate();
		idle_on = 1'b0;
		repeat (CHUNK_LEN) send_serial(pick_serial());
		idle_on = 1'b1;
	endtask

	// chunks of random serials with idling switched on and off, and a full
	// drain every few chunks
	task automatic test_random_dates();
		for (int unsigned c = 0; c < RAND_CHUNKS; c++) begin
			idle_on = ($urandom_range(0, 3) != 0);
			repeat (CHUNK_LEN) send_serial(pick_serial());
			if (c % 4 == 3) begin
				wait_all_results();
			end
		end
		idle_on = 1'b1;
	endtask

	// ---------------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------------

	initial begin
		req_ch.valid      = 1'b0;
		req_ch.day_serial = '0;
		arst_n            = 1'b0;
		idle_on           = 1'b1;
		mismatch_count    = 0;
		sent_count        = 0;
		dated_count       = 0;
		undated_count     = 0;
		checked_count     = 0;
		last_serial       = serial_of_date(BASE_YEAR + YEAR_SPAN, 1, 1) - 1;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_calendar_edges();
		test_out_of_range();
		wait_all_results();
		test_full_rate();
		test_random_dates();

		// drain, then give any stray beat time to show up
		wait_all_results();
		repeat (DRAIN_TAIL) @(negedge clk);
		if (pending_dates.size() != 0) begin
			report_mismatch("dates never returned, count", '0, pending_dates.size(), 0);
		end

		$display("run: %0d serials sent, %0d with a date and %0d out of range",
			sent_count, dated_count, undated_count);
		$display("run: %0d result beats checked, %0d mismatches", checked_count,
			mismatch_count);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/sdcd_pkg.sv
hw/rtl/sdcd_if.sv
hw/rtl/serial_day_to_calendar_date_top.sv
hw/rtl/sdcd_chk.sv
tb/tb_serial_day_to_calendar_date_top.sv
